// ----- design/cdt_pkg.sv -----
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants of the countdown timer pool: command and result
// transactions, slot modes and the layout of one slot entry in memory.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam int unsigned MAX_RESULTS    = 16;

  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_START   = 3'd1;
  localparam logic [2:0] FUNC_RESTART = 3'd2;
  localparam logic [2:0] FUNC_STOP    = 3'd3;
  localparam logic [2:0] FUNC_PAUSE   = 3'd4;
  localparam logic [2:0] FUNC_RESUME  = 3'd5;

  localparam logic EVENT_START_REPLY = 1'b0;
  localparam logic EVENT_EXPIRED     = 1'b1;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_RUNNING  = 2'd1,
    MODE_PAUSED   = 2'd2,
    MODE_FINISHED = 2'd3
  } mode_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] elapsed_ms;
    logic [31:0] duration_ms;
    logic        notify;
    logic [7:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic       event_kind;
    logic [3:0] slot_index;
    logic       start_ok;
    logic       last;
  } result_t;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] time_left;
    logic [31:0] reload_value;
    logic        report_enable;
  } entry_t;

endpackage

// ----- design/cdt_ram.sv -----
// ----------------------------------------------------------------------------
// cdt_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module cdt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/countdown_timer_pool.sv -----
// ----------------------------------------------------------------------------
// countdown_timer_pool
// A pool of countdown timers kept in one slot memory, driven by software
// commands and periodic ticks.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. A tick
// keeps busy high while every slot is read once through the single read port
// of the slot memory and written back in the cycle after, followed by the
// final report in ST_TICK_END. A start scans the in-use flags one slot per
// cycle and stays busy until it finds a free slot or has inspected the last
// one. Restart, pause and resume with a slot in range are busy only in ST_SLOT;
// a stop, an unused function code or a slot out of range never raises busy.
// Each result is shown for exactly one cycle on result_o, marked by
// result_valid_o, and must be taken then, since the receiver cannot stall
// the block. Expiry results come in slot order, at most one per cycle.
module countdown_timer_pool #(
  parameter int unsigned NumTimers = cdt_pkg::NUM_TIMERS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cdt_pkg::cmd_t    cmd_i,
  output logic             result_valid_o,
  output cdt_pkg::result_t result_o
);

  import cdt_pkg::*;

  localparam int unsigned SlotW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int unsigned CntW  = $clog2(NumTimers + 1);
  localparam int unsigned RepW  = $clog2(MAX_RESULTS + 1);
  localparam int unsigned EntW  = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TICK,
    ST_TICK_END,
    ST_SLOT
  } state_e;

  function automatic logic [3:0] to_index(logic [SlotW-1:0] idx);
    logic [7:0] wide;
    wide = 8'(idx);
    return wide[3:0];
  endfunction

  state_e               state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  cmd_t                 cmd_q, cmd_d;
  logic                 proc_live_q, proc_live_d;
  logic [SlotW-1:0]     proc_idx_q, proc_idx_d;
  logic [RepW-1:0]      rep_cnt_q, rep_cnt_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [SlotW-1:0]     pend_idx_q, pend_idx_d;
  logic [NumTimers-1:0] valid_q, valid_d;
  logic                 res_vld_q, res_vld_d;
  result_t              res_q, res_d;

  logic                 wr_en;
  logic [SlotW-1:0]     wr_addr;
  entry_t               wr_data;
  logic                 rd_en;
  logic [SlotW-1:0]     rd_addr;
  logic [EntW-1:0]      rd_data;
  entry_t               ent;
  logic [SlotW-1:0]     ent_idx;
  logic [SlotW-1:0]     scan_idx;
  logic                 slot_in_range;

  cdt_ram #(
    .Width (EntW),
    .Depth (NumTimers)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign busy          = (state_q != ST_IDLE);
  assign scan_idx      = cnt_q[SlotW-1:0];
  assign slot_in_range = ({1'b0, cmd_i.slot} < 9'(NumTimers));
  assign ent_idx       = (state_q == ST_SLOT) ? cmd_q.slot[SlotW-1:0] : proc_idx_q;
  assign ent           = valid_q[ent_idx] ? entry_t'(rd_data) : entry_t'('0);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    proc_live_d = proc_live_q;
    proc_idx_d  = proc_idx_q;
    rep_cnt_d   = rep_cnt_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    valid_d     = valid_q;
    res_vld_d   = 1'b0;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_addr     = ent_idx;
    wr_data     = ent;
    rd_en       = 1'b0;
    rd_addr     = cmd_i.slot[SlotW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          case (cmd_i.func)
            FUNC_TICK: begin
              state_d     = ST_TICK;
              cnt_d       = '0;
              proc_live_d = 1'b0;
              rep_cnt_d   = '0;
              pend_vld_d  = 1'b0;
            end
            FUNC_START: begin
              state_d = ST_SCAN;
              cnt_d   = '0;
            end
            FUNC_STOP: begin
              if (slot_in_range) begin
                valid_d[cmd_i.slot[SlotW-1:0]] = 1'b0;
              end
            end
            FUNC_RESTART, FUNC_PAUSE, FUNC_RESUME: begin
              if (slot_in_range) begin
                rd_en   = 1'b1;
                state_d = ST_SLOT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!valid_q[scan_idx]) begin
          wr_en                 = 1'b1;
          wr_addr               = scan_idx;
          wr_data.mode          = MODE_RUNNING;
          wr_data.time_left     = cmd_q.duration_ms;
          wr_data.reload_value  = cmd_q.duration_ms;
          wr_data.report_enable = cmd_q.notify;
          valid_d[scan_idx]     = 1'b1;
          res_vld_d             = 1'b1;
          res_d                 = '{EVENT_START_REPLY, to_index(scan_idx), 1'b1, 1'b1};
          state_d               = ST_IDLE;
        end else if (cnt_q == CntW'(NumTimers - 1)) begin
          res_vld_d = 1'b1;
          res_d     = '{EVENT_START_REPLY, 4'd0, 1'b0, 1'b1};
          state_d   = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_TICK: begin
        if (cnt_q < CntW'(NumTimers)) begin
          rd_en       = 1'b1;
          rd_addr     = scan_idx;
          proc_live_d = 1'b1;
          proc_idx_d  = scan_idx;
          cnt_d       = cnt_q + 1'b1;
        end else begin
          proc_live_d = 1'b0;
          state_d     = ST_TICK_END;
        end
        if (proc_live_q) begin
          case (ent.mode)
            MODE_FINISHED: begin
              valid_d[proc_idx_q] = 1'b0;
            end
            MODE_RUNNING: begin
              wr_en = 1'b1;
              if (cmd_q.elapsed_ms >= ent.time_left) begin
                wr_data.mode      = MODE_FINISHED;
                wr_data.time_left = '0;
                if (ent.report_enable && (rep_cnt_q < RepW'(MAX_RESULTS))) begin
                  if (pend_vld_q) begin
                    res_vld_d = 1'b1;
                    res_d     = '{EVENT_EXPIRED, to_index(pend_idx_q), 1'b0, 1'b0};
                  end
                  pend_vld_d = 1'b1;
                  pend_idx_d = proc_idx_q;
                  rep_cnt_d  = rep_cnt_q + 1'b1;
                end
              end else begin
                wr_data.time_left = ent.time_left - cmd_q.elapsed_ms;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_TICK_END: begin
        if (pend_vld_q) begin
          res_vld_d = 1'b1;
          res_d     = '{EVENT_EXPIRED, to_index(pend_idx_q), 1'b0, 1'b1};
        end
        pend_vld_d = 1'b0;
        state_d    = ST_IDLE;
      end

      ST_SLOT: begin
        case (cmd_q.func)
          FUNC_RESTART: begin
            if (ent.mode != MODE_INACTIVE) begin
              wr_en             = 1'b1;
              wr_data.mode      = MODE_RUNNING;
              wr_data.time_left = ent.reload_value;
            end
          end
          FUNC_PAUSE: begin
            if (ent.mode == MODE_RUNNING) begin
              wr_en        = 1'b1;
              wr_data.mode = MODE_PAUSED;
            end
          end
          FUNC_RESUME: begin
            if (ent.mode == MODE_PAUSED) begin
              wr_en        = 1'b1;
              wr_data.mode = MODE_RUNNING;
            end
          end
          default: begin
          end
        endcase
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cmd_q       <= '0;
      proc_live_q <= 1'b0;
      proc_idx_q  <= '0;
      rep_cnt_q   <= '0;
      pend_vld_q  <= 1'b0;
      pend_idx_q  <= '0;
      valid_q     <= '0;
      res_vld_q   <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cmd_q       <= cmd_d;
      proc_live_q <= proc_live_d;
      proc_idx_q  <= proc_idx_d;
      rep_cnt_q   <= rep_cnt_d;
      pend_vld_q  <= pend_vld_d;
      pend_idx_q  <= pend_idx_d;
      valid_q     <= valid_d;
      res_vld_q   <= res_vld_d;
      res_q       <= res_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the countdown timer pool. A directed table
// covers the extremes and the corner cases of the commands, then random
// commands, 450 not ignored, come in random bursts and gaps. A predictor of the slot
// memory works out the expected start replies and expiry events, and every
// result transaction is checked field by field against them in order.
// ----------------------------------------------------------------------------
module tb_top;
  import cdt_pkg::*;

  localparam int unsigned NumSlots    = NUM_TIMERS_DEF;
  localparam int unsigned RandomItems = 450;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = NumSlots + 8;

  typedef struct {
    cmd_t        cmd;
    int unsigned reps;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  cmd_t    cmd_i;
  logic    result_valid_o;
  result_t result_o;

  mode_e       slot_mode     [NumSlots];
  logic [31:0] time_left     [NumSlots];
  logic [31:0] reload_value  [NumSlots];
  logic        report_enable [NumSlots];

  result_t     cmd_events[$];
  result_t     due_events[$];
  stim_row_t   directed_rows[$];
  result_t     want;
  int unsigned error_count;
  int unsigned cycle_count;

  countdown_timer_pool DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** countdown_timer_pool: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic void clear_slot(input int k);
    slot_mode[k]     = MODE_INACTIVE;
    time_left[k]     = '0;
    reload_value[k]  = '0;
    report_enable[k] = 1'b0;
  endfunction

  function automatic void reset_pool();
    for (int k = 0; k < NumSlots; k++) clear_slot(k);
  endfunction

  function automatic void apply_command(input cmd_t c);
    int      free_slot;
    result_t ev;
    free_slot = -1;
    ev = '0;
    cmd_events.delete();
    case (c.func)
      FUNC_TICK: begin
        for (int k = 0; k < NumSlots; k++) begin
          if (slot_mode[k] == MODE_FINISHED) begin
            clear_slot(k);
          end else if (slot_mode[k] == MODE_RUNNING) begin
            if (c.elapsed_ms >= time_left[k]) begin
              time_left[k] = '0;
              slot_mode[k] = MODE_FINISHED;
              if (report_enable[k] && cmd_events.size() < MAX_RESULTS) begin
                ev.event_kind = EVENT_EXPIRED;
                ev.slot_index = 4'(k);
                ev.start_ok   = 1'b0;
                ev.last       = 1'b0;
                cmd_events.push_back(ev);
              end
            end else begin
              time_left[k] = time_left[k] - c.elapsed_ms;
            end
          end
        end
      end
      FUNC_START: begin
        for (int k = 0; k < NumSlots; k++) begin
          if (free_slot < 0 && slot_mode[k] == MODE_INACTIVE) free_slot = k;
        end
        ev.event_kind = EVENT_START_REPLY;
        ev.last       = 1'b0;
        if (free_slot >= 0) begin
          slot_mode[free_slot]     = MODE_RUNNING;
          time_left[free_slot]     = c.duration_ms;
          reload_value[free_slot]  = c.duration_ms;
          report_enable[free_slot] = c.notify;
          ev.slot_index = 4'(free_slot);
          ev.start_ok   = 1'b1;
        end else begin
          ev.slot_index = '0;
          ev.start_ok   = 1'b0;
        end
        cmd_events.push_back(ev);
      end
      FUNC_RESTART: begin
        if (c.slot < NumSlots && slot_mode[c.slot] != MODE_INACTIVE) begin
          slot_mode[c.slot] = MODE_RUNNING;
          time_left[c.slot] = reload_value[c.slot];
        end
      end
      FUNC_STOP: begin
        if (c.slot < NumSlots) clear_slot(c.slot);
      end
      FUNC_PAUSE: begin
        if (c.slot < NumSlots && slot_mode[c.slot] == MODE_RUNNING) begin
          slot_mode[c.slot] = MODE_PAUSED;
        end
      end
      FUNC_RESUME: begin
        if (c.slot < NumSlots && slot_mode[c.slot] == MODE_PAUSED) begin
          slot_mode[c.slot] = MODE_RUNNING;
        end
      end
      default: ;
    endcase
    if (cmd_events.size() > 0) begin
      ev = cmd_events.pop_back();
      ev.last = 1'b1;
      cmd_events.push_back(ev);
    end
  endfunction

  function automatic result_t start_reply(input logic [3:0] idx, input logic ok);
    result_t r;
    r.event_kind = EVENT_START_REPLY;
    r.slot_index = idx;
    r.start_ok   = ok;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] func, input logic [31:0] elapsed,
                                  input logic [31:0] duration, input logic notify,
                                  input logic [7:0] slot, input int unsigned reps,
                                  input bit typed, input result_t typed_want);
    stim_row_t row;
    row.cmd.func        = func;
    row.cmd.elapsed_ms  = elapsed;
    row.cmd.duration_ms = duration;
    row.cmd.notify      = notify;
    row.cmd.slot        = slot;
    row.reps            = reps;
    row.typed           = typed;
    row.want            = typed_want;
    directed_rows.push_back(row);
  endfunction

  function automatic void load_directed();
    add_row(FUNC_START,   '0, '1,    1'b1, '0,    1, 1'b1, start_reply(4'd0, 1'b1));
    add_row(FUNC_START,   '0, '0,    1'b1, '0,    1, 1'b1, start_reply(4'd1, 1'b1));
    add_row(FUNC_START,   '0, 32'd5, 1'b0, '0,    1, 1'b1, start_reply(4'd2, 1'b1));
    add_row(FUNC_TICK,    '0, '0,    1'b0, '0,    1, 1'b0, '0);
    add_row(FUNC_PAUSE,   '0, '0,    1'b0, 8'd0,  1, 1'b0, '0);
    add_row(FUNC_RESTART, '0, '0,    1'b0, 8'd1,  1, 1'b0, '0);
    add_row(FUNC_STOP,    '0, '0,    1'b0, '1,    1, 1'b0, '0);
    add_row(FUNC_TICK,    '1, '0,    1'b1, '0,    1, 1'b0, '0);
    add_row(FUNC_RESTART, '0, '0,    1'b0, 8'd0,  1, 1'b0, '0);
    add_row(FUNC_START,   '0, 32'd3, 1'b1, '0,   13, 1'b0, '0);
    add_row(FUNC_START,   '0, '1,    1'b1, '0,    1, 1'b1, start_reply(4'd0, 1'b0));
    add_row(FUNC_RESTART, '0, '0,    1'b0, 8'd1,  1, 1'b0, '0);
    add_row(FUNC_RESTART, '0, '0,    1'b0, 8'd2,  1, 1'b0, '0);
    add_row(FUNC_TICK,    '1, '0,    1'b0, '0,    1, 1'b0, '0);
  endfunction

  function automatic cmd_t random_command();
    cmd_t        c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 34) c.func = FUNC_TICK;
    else if (pick < 58) c.func = FUNC_START;
    else if (pick < 68) c.func = FUNC_RESTART;
    else if (pick < 77) c.func = FUNC_STOP;
    else if (pick < 86) c.func = FUNC_PAUSE;
    else if (pick < 95) c.func = FUNC_RESUME;
    else c.func = FUNC_RESUME + 3'($urandom_range(1, 2));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: c.elapsed_ms = $urandom_range(0, 20);
      5, 6, 7:       c.elapsed_ms = $urandom_range(0, 300);
      8:             c.elapsed_ms = $urandom;
      default:       c.elapsed_ms = '1;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: c.duration_ms = $urandom_range(0, 60);
      6, 7:             c.duration_ms = $urandom_range(0, 500);
      8:                c.duration_ms = $urandom;
      default:          c.duration_ms = '0;
    endcase
    c.notify = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) != 0) c.slot = 8'($urandom_range(0, NumSlots - 1));
    else c.slot = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic bit is_ignored(input cmd_t c);
    return c.func > FUNC_RESUME ||
           (c.func != FUNC_TICK && c.func != FUNC_START && c.slot >= NumSlots);
  endfunction

  task automatic issue(input cmd_t c, input bit typed, input result_t typed_want);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    apply_command(c);
    if (typed) due_events.push_back(typed_want);
    else foreach (cmd_events[i]) due_events.push_back(cmd_events[i]);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o === 1'b1) begin
        if (due_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", result_o));
        end else begin
          want = due_events.pop_front();
          if (result_o.event_kind !== want.event_kind)
            report_mismatch($sformatf("event_kind got %b want %b",
                                      result_o.event_kind, want.event_kind));
          if (result_o.slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index got %0d want %0d",
                                      result_o.slot_index, want.slot_index));
          if (result_o.start_ok !== want.start_ok)
            report_mismatch($sformatf("start_ok got %b want %b",
                                      result_o.start_ok, want.start_ok));
          if (result_o.last !== want.last)
            report_mismatch($sformatf("last got %b want %b",
                                      result_o.last, want.last));
        end
      end else if (result_valid_o !== 1'b0) begin
        report_mismatch("result_valid_o is unknown");
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst_left;
    cmd_t        c;
    error_count = 0;
    cycle_count = 0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    cmd_i  <= '0;
    reset_pool();
    load_directed();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int n = 0; n < directed_rows[r].reps; n++) begin
        issue(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);
        if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 6));
      end
    end

    sent = 0;
    burst_left = $urandom_range(1, 24);
    while (sent < RandomItems) begin
      c = random_command();
      issue(c, 1'b0, '0);
      if (!is_ignored(c)) sent++;
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 20));
        burst_left = $urandom_range(1, 24);
      end
    end

    start <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** countdown_timer_pool: PASSED **");
    end else begin
      $display("** countdown_timer_pool: FAILED **");
    end
    $finish;
  end

endmodule

// ----- countdown_timer_pool.f -----
design/cdt_pkg.sv
design/cdt_ram.sv
design/countdown_timer_pool.sv
tb/tb_top.sv
